[sv/ortb_pkg.sv]
// Shared types and constants for the overwrite ring trace buffer.
package ortb_pkg;

	localparam int unsigned RING_DEPTH_DEF = 16384;
	localparam int unsigned POS_W          = 32;
	localparam int unsigned LEN_W          = 7;
	localparam int unsigned IN_DATA_W      = 48;
	localparam int unsigned OUT_DATA_W     = 112;
	localparam logic [LEN_W-1:0] READ_LIMIT = 7'd64;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// request to the shared adder/subtractor
	typedef struct packed {
		logic [POS_W-1:0] a;
		logic [POS_W-1:0] b;
		logic             sub;
	} alu_req_t;

	// carry out is set for a subtract when a >= b
	typedef struct packed {
		logic [POS_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

endpackage

[sv/overwrite_ring_trace_buffer.sv]
// Overwrite-oldest byte trace ring: top level with read sequencer and output register.
// Write request: taken in the idle state, which a write does not leave, so writes stream at one a cycle between reads.
// Read request: seven sequencer steps on the shared 32-bit adder, then one result per cycle
//   while the output is not stalled. The next request may be taken while the final result waits.
// Reset (arst_n low, asynchronous) clears the write count and control; ring contents are
//   not cleared, and need not be, since reads only reach bytes already written.
module overwrite_ring_trace_buffer
	import ortb_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input requests
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// write_byte[7:0], read_position[39:8], max_length[46:40], zero pad [47]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation[0]
	input  logic                  s_tuser,
	// results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// data_byte[7:0], reader_position[39:8], byte_count[46:40],
	// write_position[78:47], oldest_position[110:79], zero pad [111]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// byte_valid[0]
	output logic                  m_tuser,
	output logic                  m_tlast
);

	localparam int unsigned SW = $clog2(RING_DEPTH);
	localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_OLD   = 9'b000000010,  // oldest = wc - depth when wc > depth
		ST_CLAMP = 9'b000000100,  // raise position to oldest
		ST_AVAIL = 9'b000001000,  // bytes available = wc - pos
		ST_MIN   = 9'b000010000,  // count = min(avail, limit)
		ST_SLOT  = 9'b000100000,  // start slot = write slot - avail ...
		ST_SLOT2 = 9'b001000000,  // ... plus depth on borrow
		ST_NPOS  = 9'b010000000,  // new reader position = pos + count
		ST_RUN   = 9'b100000000   // stream bytes out
	} state_t;

	state_t state_q;

	// persistent state
	logic [POS_W-1:0] wc_q;
	logic [SW-1:0]    wr_slot_q;

	// read working registers
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] lim_q;
	logic [POS_W-1:0] oldest_q;
	logic [SW:0]      avail_q;
	logic [LEN_W-1:0] n_q;
	logic [LEN_W-1:0] rem_q;
	logic [POS_W-1:0] tmp_q;
	logic             borrow_q;
	logic [SW-1:0]    rd_slot_q;
	logic [POS_W-1:0] newpos_q;

	// output register
	logic             out_valid_q;
	logic             out_bv_q;
	logic             out_last_q;
	logic [POS_W-1:0] out_pos_q;
	logic [LEN_W-1:0] out_cnt_q;
	logic [POS_W-1:0] out_wc_q;
	logic [POS_W-1:0] out_old_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic             in_acc;
	logic             wr_acc;
	logic             issue;
	logic             rd_en;
	logic [7:0]       rd_data;
	logic [LEN_W-1:0] in_len;
	logic             sum_zero;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign wr_acc   = in_acc && (s_tuser == OP_WRITE);
	assign in_len   = (s_tdata[46:40] > READ_LIMIT) ? READ_LIMIT : s_tdata[46:40];
	assign sum_zero = (alu_rsp.sum == '0);

	// a result slot is free when the output register is empty or being drained
	assign issue = (state_q == ST_RUN) && (!out_valid_q || m_tready);
	assign rd_en = issue && (n_q != '0);

	ortb_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ortb_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_acc),
		.wr_addr (wr_slot_q),
		.wr_data (s_tdata[7:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_slot_q),
		.rd_data (rd_data)
	);

	// operand selection for the shared adder, one operation per step
	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_OLD: begin
				alu_req.a   = wc_q;
				alu_req.b   = POS_W'(RING_DEPTH);
				alu_req.sub = 1'b1;
			end
			ST_CLAMP: begin
				alu_req.a   = pos_q;
				alu_req.b   = oldest_q;
				alu_req.sub = 1'b1;
			end
			ST_AVAIL: begin
				alu_req.a   = wc_q;
				alu_req.b   = pos_q;
				alu_req.sub = 1'b1;
			end
			ST_MIN: begin
				alu_req.a   = POS_W'(avail_q);
				alu_req.b   = POS_W'(lim_q);
				alu_req.sub = 1'b1;
			end
			ST_SLOT: begin
				alu_req.a   = POS_W'(wr_slot_q);
				alu_req.b   = POS_W'(avail_q);
				alu_req.sub = 1'b1;
			end
			ST_SLOT2: begin
				alu_req.a   = tmp_q;
				alu_req.b   = borrow_q ? POS_W'(RING_DEPTH) : '0;
				alu_req.sub = 1'b0;
			end
			ST_NPOS: begin
				alu_req.a   = pos_q;
				alu_req.b   = POS_W'(n_q);
				alu_req.sub = 1'b0;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	// control: sequencer state, write count and slot, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wc_q        <= '0;
			wr_slot_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == OP_WRITE) begin
							wc_q <= wc_q + 32'd1;
							// count wraps to zero, and so does its slot
							if (wc_q == '1) begin
								wr_slot_q <= '0;
							end else if (wr_slot_q == LAST_SLOT) begin
								wr_slot_q <= '0;
							end else begin
								wr_slot_q <= wr_slot_q + 1'b1;
							end
						end else begin
							state_q <= ST_OLD;
						end
					end
				end
				ST_OLD:   state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_AVAIL;
				ST_AVAIL: state_q <= ST_MIN;
				ST_MIN:   state_q <= ST_SLOT;
				ST_SLOT:  state_q <= ST_SLOT2;
				ST_SLOT2: state_q <= ST_NPOS;
				ST_NPOS:  state_q <= ST_RUN;
				ST_RUN: begin
					if (issue && ((n_q == '0) || (rem_q == 7'd1))) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working and output payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					pos_q <= s_tdata[39:8];
					lim_q <= in_len;
				end
			end
			ST_OLD: begin
				// wc > depth exactly when the subtract neither borrows nor hits zero
				oldest_q <= (alu_rsp.carry && !sum_zero) ? alu_rsp.sum : '0;
			end
			ST_CLAMP: begin
				// a zero-length read keeps the position as given
				if ((lim_q != '0) && !alu_rsp.carry) begin
					pos_q <= oldest_q;
				end
			end
			ST_AVAIL: begin
				// after clamping, avail never exceeds the depth
				if ((lim_q == '0) || !alu_rsp.carry || sum_zero) begin
					avail_q <= '0;
				end else begin
					avail_q <= (SW+1)'(alu_rsp.sum);
				end
			end
			ST_MIN: begin
				n_q <= alu_rsp.carry ? lim_q : LEN_W'(avail_q);
			end
			ST_SLOT: begin
				tmp_q    <= alu_rsp.sum;
				borrow_q <= !alu_rsp.carry;
			end
			ST_SLOT2: begin
				rd_slot_q <= alu_rsp.sum[SW-1:0];
			end
			ST_NPOS: begin
				newpos_q <= alu_rsp.sum;
				rem_q    <= n_q;
			end
			ST_RUN: begin
				if (rd_en) begin
					rem_q <= rem_q - 7'd1;
					rd_slot_q <= (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (issue) begin
			out_bv_q   <= (n_q != '0);
			out_last_q <= (n_q == '0) || (rem_q == 7'd1);
			out_pos_q  <= newpos_q;
			out_cnt_q  <= n_q;
			out_wc_q   <= wc_q;
			out_old_q  <= oldest_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_bv_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_old_q, out_wc_q, out_cnt_q, out_pos_q,
		(out_bv_q ? rd_data : 8'h00)};

	// a byte-carrying result belongs to a read with a non-zero count
	a_bv_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[46:40] != '0))
		else $error("byte result with zero count");

	// an empty read is always a single, final result
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("empty result not marked last");

	// the oldest kept position never lies past the write count
	a_oldest_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[110:79] <= m_tdata[78:47]))
		else $error("oldest position beyond write count");

	// the byte counter never exceeds the read limit while streaming
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((rem_q <= READ_LIMIT) && (n_q <= READ_LIMIT)))
		else $error("read count beyond limit");

endmodule

[sv/ortb_alu.sv]
// Shared 32-bit add/subtract unit used by the read sequencer.
module ortb_alu
	import ortb_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [POS_W:0] full;

	always_comb begin
		if (req.sub) begin
			full = {1'b0, req.a} + {1'b0, ~req.b} + {{POS_W{1'b0}}, 1'b1};
		end else begin
			full = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.sum   = full[POS_W-1:0];
		rsp.carry = full[POS_W];
	end

endmodule

[sv/ortb_ring.sv]
// Byte ring storage: one write port, one registered read port.
module ortb_ring
	import ortb_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
	localparam int unsigned SW = $clog2(RING_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [SW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [SW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
